// File: rtl/i2cee_pkg.sv
`default_nettype none
package i2cee_pkg;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_START   = 5'd1,
    PH_SEND_DW = 5'd2,
    PH_ACK_DW  = 5'd3,
    PH_SEND_HI = 5'd4,
    PH_ACK_HI  = 5'd5,
    PH_SEND_LO = 5'd6,
    PH_ACK_LO  = 5'd7,
    PH_RESTART = 5'd8,
    PH_SEND_DR = 5'd9,
    PH_ACK_DR  = 5'd10,
    PH_READ    = 5'd11,
    PH_NACK    = 5'd12,
    PH_STOP    = 5'd13
  } phase_t;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_ID_WRITE  = 3'd1;
  localparam logic [2:0] ERR_HIGH_ADDR = 3'd2;
  localparam logic [2:0] ERR_LOW_ADDR  = 3'd3;
  localparam logic [2:0] ERR_ID_READ   = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  device_byte;
    logic [15:0] word_address;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [2:0] error_code;
    logic [7:0] read_data;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/i2c_master_eeprom_random_read_core.sv
// Bit-level I2C master for one random byte read from an EEPROM with a 16-bit
// word address. An item with tuser set starts a transaction when the master is
// idle; every other item is one bus delay period that carries the sampled SDA
// level and returns the SCL and SDA levels to drive for that period, plus busy,
// done, an error code and the byte read. Every input item gives exactly one
// result item. The block takes one item per clock cycle while results are
// taken: an input register feeds the bit sequencer, whose single step of logic
// fills the result register. While the result is not taken, that register and
// the sequencer hold; the input register then takes an item only while empty.
`default_nettype none
module i2c_master_eeprom_random_read_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // device_byte, word_address, sda_in
  input  wire logic [0:0]  s_tuser,  // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata   // scl_out, sda_out, busy_res, done_res,
                                     // error_code, read_data
);
  import i2cee_pkg::*;

  logic  in_valid;
  item_t in_item;
  logic  out_valid;
  res_t  out_res;
  res_t  res;
  logic  advance;
  logic  step;

  assign advance = !out_valid || m_tready;
  assign step = in_valid && advance;
  assign s_tready = !in_valid || advance;

  i2cee_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind <= s_tuser[0];
      in_item.device_byte <= s_tdata[7:0];
      in_item.word_address <= s_tdata[23:8];
      in_item.sda_in <= s_tdata[24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {1'b0, out_res.read_data, out_res.error_code, out_res.done_res,
                    out_res.busy_res, out_res.sda_out, out_res.scl_out};

endmodule
`default_nettype wire

// File: rtl/i2cee_seq.sv
`default_nettype none
module i2cee_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire i2cee_pkg::item_t item,
  output i2cee_pkg::res_t     res
);
  import i2cee_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  sub_step, sub_step_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [7:0]  held_device, held_device_next;
  logic [15:0] held_address, held_address_next;
  logic [7:0]  received_byte, received_byte_next;
  logic [2:0]  last_error, last_error_next;
  logic        line_scl, line_scl_next;
  logic        line_sda, line_sda_next;
  logic        busy;

  function automatic logic [7:0] enter_shift(phase_t p, logic [7:0] dev,
                                             logic [15:0] addr, logic [7:0] cur);
    logic [7:0] r;
    r = cur;
    case (p)
      PH_SEND_DW: r = dev;
      PH_SEND_HI: r = addr[15:8];
      PH_SEND_LO: r = addr[7:0];
      PH_SEND_DR: r = dev | 8'h01;
      PH_READ:    r = 8'h00;
      default:    r = cur;
    endcase
    return r;
  endfunction

  assign busy = (phase != PH_IDLE);

  always_comb begin
    res = '0;
    res.scl_out = 1'b1;
    res.sda_out = 1'b1;
    res.busy_res = 1'b1;
    if (item.kind == KIND_START) begin
      res.scl_out = busy ? line_scl : 1'b1;
      res.sda_out = busy ? line_sda : 1'b1;
    end else begin
      case (phase)
        PH_START, PH_RESTART: begin
          res.scl_out = (sub_step < 2'd2);
          res.sda_out = (sub_step == 2'd0);
        end
        PH_SEND_DW, PH_SEND_HI, PH_SEND_LO, PH_SEND_DR: begin
          res.scl_out = (sub_step == 2'd1);
          res.sda_out = shift_reg[7];
        end
        PH_ACK_DW, PH_ACK_HI, PH_ACK_LO, PH_ACK_DR, PH_NACK: begin
          res.scl_out = (sub_step == 2'd1);
        end
        PH_READ: begin
          res.scl_out = (sub_step == 2'd0);
        end
        PH_STOP: begin
          res.scl_out = (sub_step >= 2'd2);
          res.sda_out = (sub_step == 2'd0) || (sub_step == 2'd3);
          if (sub_step == 2'd3) begin
            res.done_res = 1'b1;
            res.error_code = last_error;
            res.read_data = (last_error == ERR_OK) ? received_byte : 8'h00;
          end
        end
        default: begin
          res.busy_res = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    logic       do_enter;
    phase_t     target;
    do_enter = 1'b0;
    target = PH_IDLE;
    phase_next = phase;
    sub_step_next = sub_step;
    bit_count_next = bit_count;
    shift_reg_next = shift_reg;
    held_device_next = held_device;
    held_address_next = held_address;
    received_byte_next = received_byte;
    last_error_next = last_error;
    line_scl_next = line_scl;
    line_sda_next = line_sda;
    if (item.kind == KIND_START) begin
      if (!busy) begin
        held_device_next = item.device_byte;
        held_address_next = item.word_address;
        last_error_next = ERR_OK;
        received_byte_next = 8'h00;
        line_scl_next = 1'b1;
        line_sda_next = 1'b1;
        do_enter = 1'b1;
        target = PH_START;
      end
    end else begin
      line_scl_next = res.scl_out;
      line_sda_next = res.sda_out;
      case (phase)
        PH_START, PH_RESTART: begin
          if (sub_step >= 2'd2) begin
            do_enter = 1'b1;
            target = (phase == PH_START) ? PH_SEND_DW : PH_SEND_DR;
          end else begin
            sub_step_next = sub_step + 2'd1;
          end
        end
        PH_SEND_DW, PH_SEND_HI, PH_SEND_LO, PH_SEND_DR: begin
          if (sub_step < 2'd2) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            shift_reg_next = {shift_reg[6:0], 1'b0};
            if (bit_count == 3'd7) begin
              do_enter = 1'b1;
              case (phase)
                PH_SEND_DW: target = PH_ACK_DW;
                PH_SEND_HI: target = PH_ACK_HI;
                PH_SEND_LO: target = PH_ACK_LO;
                default:    target = PH_ACK_DR;
              endcase
            end else begin
              bit_count_next = bit_count + 3'd1;
              sub_step_next = 2'd0;
            end
          end
        end
        PH_ACK_DW, PH_ACK_HI, PH_ACK_LO, PH_ACK_DR: begin
          if (sub_step == 2'd0) begin
            sub_step_next = 2'd1;
          end else if (sub_step == 2'd1) begin
            if (item.sda_in) begin
              case (phase)
                PH_ACK_DW: last_error_next = ERR_ID_WRITE;
                PH_ACK_HI: last_error_next = ERR_HIGH_ADDR;
                PH_ACK_LO: last_error_next = ERR_LOW_ADDR;
                default:   last_error_next = ERR_ID_READ;
              endcase
              do_enter = 1'b1;
              target = PH_STOP;
            end else begin
              sub_step_next = 2'd2;
            end
          end else begin
            do_enter = 1'b1;
            case (phase)
              PH_ACK_DW: target = PH_SEND_HI;
              PH_ACK_HI: target = PH_SEND_LO;
              PH_ACK_LO: target = PH_RESTART;
              default:   target = PH_READ;
            endcase
          end
        end
        PH_READ: begin
          if (sub_step == 2'd0) begin
            shift_reg_next = {shift_reg[6:0], item.sda_in};
            sub_step_next = 2'd1;
          end else if (bit_count == 3'd7) begin
            received_byte_next = shift_reg;
            do_enter = 1'b1;
            target = PH_NACK;
          end else begin
            bit_count_next = bit_count + 3'd1;
            sub_step_next = 2'd0;
          end
        end
        PH_NACK: begin
          if (sub_step < 2'd2) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            do_enter = 1'b1;
            target = PH_STOP;
          end
        end
        PH_STOP: begin
          if (sub_step == 2'd3) begin
            do_enter = 1'b1;
            target = PH_IDLE;
          end else begin
            sub_step_next = sub_step + 2'd1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
    if (do_enter) begin
      phase_next = target;
      sub_step_next = 2'd0;
      bit_count_next = 3'd0;
      shift_reg_next = enter_shift(target, held_device_next, held_address_next,
                                   shift_reg_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      sub_step <= 2'd0;
      bit_count <= 3'd0;
      shift_reg <= 8'h00;
      held_device <= 8'h00;
      held_address <= 16'h0000;
      received_byte <= 8'h00;
      last_error <= ERR_OK;
      line_scl <= 1'b1;
      line_sda <= 1'b1;
    end else if (step) begin
      phase <= phase_next;
      sub_step <= sub_step_next;
      bit_count <= bit_count_next;
      shift_reg <= shift_reg_next;
      held_device <= held_device_next;
      held_address <= held_address_next;
      received_byte <= received_byte_next;
      last_error <= last_error_next;
      line_scl <= line_scl_next;
      line_sda <= line_sda_next;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |=> phase == PH_IDLE)
    else $error("sequencer not idle after finishing a transaction");

  a_error_clears_data: assert property (@(posedge clk) disable iff (rst)
    res.done_res && res.error_code != ERR_OK |-> res.read_data == 8'h00)
    else $error("read data shown with a failed transaction");

  a_idle_lines_released: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> line_scl && line_sda)
    else $error("bus lines held while idle");

  a_stop_ends_high: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |-> res.scl_out && res.sda_out)
    else $error("stop condition did not release both lines");

endmodule
`default_nettype wire
